[src/sbg_pkg.sv]
// Shared types, constants and the LPS transform of the Streebog-512 engine.
package sbg_pkg;

    localparam int unsigned ROUNDS_DEF = 12;
    localparam int unsigned QDEPTH_DEF = 2;
    localparam int unsigned BLK_BITS   = 512;

    typedef struct packed {
        logic [511:0] data;
        logic [9:0]   bits;
        logic         fin;
    } t_job;

    localparam logic [7:0] SBOX [256] = '{
        8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,
        8'd251,8'd196,8'd250,8'd218,8'd35,8'd197,8'd4,8'd77,
        8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,
        8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,
        8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,
        8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
        8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,
        8'd6,8'd11,8'd237,8'd152,8'd127,8'd212,8'd211,8'd31,
        8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,
        8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,
        8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,
        8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
        8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,
        8'd243,8'd145,8'd120,8'd111,8'd157,8'd158,8'd178,8'd177,
        8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,
        8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,
        8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,
        8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
        8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,
        8'd220,8'd232,8'd40,8'd80,8'd78,8'd51,8'd10,8'd74,
        8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,
        8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,
        8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,
        8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
        8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,
        8'd48,8'd55,8'd107,8'd228,8'd136,8'd217,8'd231,8'd137,
        8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,
        8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,
        8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,
        8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
        8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,
        8'd209,8'd102,8'd175,8'd194,8'd57,8'd75,8'd99,8'd182
    };

    // row j is folded in when bit (63 - j) is set
    localparam logic [63:0] LIN [64] = '{
        64'h8e20faa72ba0b470,64'h47107ddd9b505a38,64'had08b0e0c3282d1c,64'hd8045870ef14980e,
        64'h6c022c38f90a4c07,64'h3601161cf205268d,64'h1b8e0b0e798c13c8,64'h83478b07b2468764,
        64'ha011d380818e8f40,64'h5086e740ce47c920,64'h2843fd2067adea10,64'h14aff010bdd87508,
        64'h0ad97808d06cb404,64'h05e23c0468365a02,64'h8c711e02341b2d01,64'h46b60f011a83988e,
        64'h90dab52a387ae76f,64'h486dd4151c3dfdb9,64'h24b86a840e90f0d2,64'h125c354207487869,
        64'h092e94218d243cba,64'h8a174a9ec8121e5d,64'h4585254f64090fa0,64'haccc9ca9328a8950,
        64'h9d4df05d5f661451,64'hc0a878a0a1330aa6,64'h60543c50de970553,64'h302a1e286fc58ca7,
        64'h18150f14b9ec46dd,64'h0c84890ad27623e0,64'h0642ca05693b9f70,64'h0321658cba93c138,
        64'h86275df09ce8aaa8,64'h439da0784e745554,64'hafc0503c273aa42a,64'hd960281e9d1d5215,
        64'he230140fc0802984,64'h71180a8960409a42,64'hb60c05ca30204d21,64'h5b068c651810a89e,
        64'h456c34887a3805b9,64'hac361a443d1c8cd2,64'h561b0d22900e4669,64'h2b838811480723ba,
        64'h9bcf4486248d9f5d,64'hc3e9224312c8c1a0,64'heffa11af0964ee50,64'hf97d86d98a327728,
        64'he4fa2054a80b329c,64'h727d102a548b194e,64'h39b008152acb8227,64'h9258048415eb419d,
        64'h492c024284fbaec0,64'haa16012142f35760,64'h550b8e9e21f7a530,64'ha48b474f9ef5dc18,
        64'h70a6a56e2440598e,64'h3853dc371220a247,64'h1ca76e95091051ad,64'h0edd37c48a08a6d8,
        64'h07e095624504536c,64'h8d70c431ac02a736,64'hc83862965601dd1b,64'h641c314b2b8ee083
    };

    // round constants, word 0 in the top 64 bits
    localparam logic [511:0] RC [12] = '{
        {64'hb1085bda1ecadae9,64'hebcb2f81c0657c1f,64'h2f6a76432e45d016,64'h714eb88d7585c4fc,
         64'h4b7ce09192676901,64'ha2422a08a460d315,64'h05767436cc744d23,64'hdd806559f2a64507},
        {64'h6fa3b58aa99d2f1a,64'h4fe39d460f70b5d7,64'hf3feea720a232b98,64'h61d55e0f16b50131,
         64'h9ab5176b12d69958,64'h5cb561c2db0aa7ca,64'h55dda21bd7cbcd56,64'he679047021b19bb7},
        {64'hf574dcac2bce2fc7,64'h0a39fc286a3d8435,64'h06f15e5f529c1f8b,64'hf2ea7514b1297b7b,
         64'hd3e20fe490359eb1,64'hc1c93a376062db09,64'hc2b6f443867adb31,64'h991e96f50aba0ab2},
        {64'hef1fdfb3e81566d2,64'hf948e1a05d71e4dd,64'h488e857e335c3c7d,64'h9d721cad685e353f,
         64'ha9d72c82ed03d675,64'hd8b71333935203be,64'h3453eaa193e837f1,64'h220cbebc84e3d12e},
        {64'h4bea6bacad474799,64'h9a3f410c6ca92363,64'h7f151c1f1686104a,64'h359e35d7800fffbd,
         64'hbfcd1747253af5a3,64'hdfff00b723271a16,64'h7a56a27ea9ea63f5,64'h601758fd7c6cfe57},
        {64'hae4faeae1d3ad3d9,64'h6fa4c33b7a3039c0,64'h2d66c4f95142a46c,64'h187f9ab49af08ec6,
         64'hcffaa6b71c9ab7b4,64'h0af21f66c2bec6b6,64'hbf71c57236904f35,64'hfa68407a46647d6e},
        {64'hf4c70e16eeaac5ec,64'h51ac86febf240954,64'h399ec6c7e6bf87c9,64'hd3473e33197a93c9,
         64'h0992abc52d822c37,64'h06476983284a0504,64'h3517454ca23c4af3,64'h8886564d3a14d493},
        {64'h9b1f5b424d93c9a7,64'h03e7aa020c6e4141,64'h4eb7f8719c36de1e,64'h89b4443b4ddbc49a,
         64'hf4892bcb929b0690,64'h69d18d2bd1a5c42f,64'h36acc2355951a8d9,64'ha47f0dd4bf02e71e},
        {64'h378f5a541631229b,64'h944c9ad8ec165fde,64'h3a7d3a1b25894224,64'h3cd955b7e00d0984,
         64'h800a440bdbb2ceb1,64'h7b2b8a9aa6079c54,64'h0e38dc92cb1f2a60,64'h7261445183235adb},
        {64'habbedea680056f52,64'h382ae548b2e4f3f3,64'h8941e71cff8a78db,64'h1fffe18a1b336103,
         64'h9fe76702af69334b,64'h7a1e6c303b7652f4,64'h3698fad1153bb6c3,64'h74b4c7fb98459ced},
        {64'h7bcd9ed0efc889fb,64'h3002c6cd635afe94,64'hd8fa6bbbebab0761,64'h2001802114846679,
         64'h8a1d71efea48b9ca,64'hefbacd1d7d476e98,64'hdea2594ac06fd85d,64'h6bcaa4cd81f32d1b},
        {64'h378ee767f11631ba,64'hd21380b00449b17a,64'hcda43c32bcdf1d77,64'hf82012d430219f9b,
         64'h5d80ef9d1891cc86,64'he71da4aa88e12852,64'hfaf417d5d9b21b99,64'h48bc924af11bd720}
    };

    function automatic logic [511:0] lps(input logic [511:0] x);
        logic [511:0] y;
        logic [63:0]  v;
        logic [63:0]  t;
        y = '0;
        for (int w = 0; w < 8; w++) begin
            v = '0;
            for (int b = 0; b < 8; b++) begin
                v[63-8*b -: 8] = SBOX[x[511-64*b-8*w -: 8]];
            end
            t = '0;
            for (int j = 0; j < 64; j++) begin
                if (v[63-j]) begin
                    t = t ^ LIN[j];
                end
            end
            y[511-64*w -: 64] = t;
        end
        return y;
    endfunction

endpackage

[src/sbg_front.sv]
// Front end: collects message words into blocks and issues block jobs.
module sbg_front
    import sbg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_data_word,
    input  logic [9:0]  i_block_bits,
    input  logic        i_message_end,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_job        o_q_job
);

    logic [63:0] r_buf [8];
    logic [63:0] n_buf [8];
    logic [2:0]  r_pos;
    logic        w_acc;

    assign o_stall = i_q_full;
    assign w_acc   = i_valid && !i_q_full;

    always_comb begin
        for (int w = 0; w < 8; w++) begin
            n_buf[w] = (r_pos == 3'(w)) ? i_data_word : r_buf[w];
        end
    end

    always_comb begin
        for (int w = 0; w < 8; w++) begin
            o_q_job.data[511-64*w -: 64] = n_buf[w];
        end
        o_q_job.bits = i_block_bits;
        o_q_job.fin  = i_message_end;
    end

    assign o_q_push = w_acc && (i_message_end || r_pos == 3'd7);

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_buf[r_pos] <= i_data_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (w_acc) begin
            r_pos <= i_message_end ? 3'd0 : r_pos + 3'd1;
        end
    end

endmodule

[src/sbg_fifo.sv]
// Short job queue between the front and back ends.
module sbg_fifo
    import sbg_pkg::*;
#(
    parameter int unsigned DEPTH = QDEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

endmodule

[src/sbg_back.sv]
// Back end: compression with one shared LPS unit, finalisation and digest output.
module sbg_back
    import sbg_pkg::*;
#(
    parameter int unsigned ROUNDS = ROUNDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_job        i_q_job,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_hash_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    localparam int unsigned RW = $clog2(ROUNDS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_KINIT = 5'b00010,
        S_RS    = 5'b00100,
        S_RK    = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        STEP_RAW  = 2'd0,
        STEP_PAD  = 2'd1,
        STEP_NFIN = 2'd2,
        STEP_SFIN = 2'd3
    } t_step;

    t_state         r_state;
    t_step          r_step;
    t_job           r_job;
    logic [RW-1:0]  r_rnd;
    logic [511:0]   r_h, r_n, r_sig, r_k, r_s, r_m, r_dig;
    logic           r_ebusy;
    logic [2:0]     r_ecnt;

    logic [8:0]     w_padk;
    logic [511:0]   w_pad, w_msel, w_nsel, w_lin, w_lout, w_mask, w_hnew;
    logic [9:0]     w_add;

    // clamp oversized length; a full final block is padded as an empty one
    assign w_padk = (r_job.bits >= 10'(BLK_BITS)) ? 9'd0 : r_job.bits[8:0];

    always_comb begin
        for (int i = 0; i < 512; i++) begin
            w_mask[i] = (i < int'(w_padk));
        end
        w_pad = (r_job.data & w_mask) | (512'd1 << w_padk);
    end

    always_comb begin
        unique case (r_step)
            STEP_RAW:  begin w_msel = r_job.data; w_nsel = r_n; w_add = 10'(BLK_BITS); end
            STEP_PAD:  begin w_msel = w_pad;      w_nsel = r_n; w_add = {1'b0, w_padk}; end
            STEP_NFIN: begin w_msel = r_n;        w_nsel = '0;  w_add = '0; end
            STEP_SFIN: begin w_msel = r_sig;      w_nsel = '0;  w_add = '0; end
            default:   begin w_msel = r_job.data; w_nsel = r_n; w_add = '0; end
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_KINIT: w_lin = r_h ^ w_nsel;
            S_RK:    w_lin = r_k ^ RC[r_rnd];
            default: w_lin = r_s;
        endcase
    end

    assign w_lout  = lps(w_lin);
    assign w_hnew  = r_h ^ r_s ^ r_m;
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= STEP_RAW;
            r_rnd   <= '0;
            r_h     <= '0;
            r_n     <= '0;
            r_sig   <= '0;
            r_ebusy <= 1'b0;
            r_ecnt  <= '0;
        end else begin
            if (r_ebusy && !i_stall) begin
                r_ecnt <= r_ecnt + 3'd1;
                if (r_ecnt == 3'd7) begin
                    r_ebusy <= 1'b0;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_job   <= i_q_job;
                        r_step  <= (!i_q_job.fin || i_q_job.bits >= 10'(BLK_BITS))
                                   ? STEP_RAW : STEP_PAD;
                        r_state <= S_KINIT;
                    end
                end
                S_KINIT: begin
                    r_k     <= w_lout;
                    r_s     <= w_lout ^ w_msel;
                    r_m     <= w_msel;
                    r_rnd   <= '0;
                    r_state <= S_RS;
                end
                S_RS: begin
                    r_s     <= w_lout;
                    r_state <= S_RK;
                end
                S_RK: begin
                    r_k <= w_lout;
                    r_s <= r_s ^ w_lout;
                    if (r_rnd == RW'(ROUNDS - 1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_rnd   <= r_rnd + RW'(1);
                        r_state <= S_RS;
                    end
                end
                S_FIN: begin
                    unique case (r_step)
                        STEP_RAW, STEP_PAD: begin
                            r_h   <= w_hnew;
                            r_n   <= r_n + {502'd0, w_add};
                            r_sig <= r_sig + r_m;
                            if (r_step == STEP_RAW && !r_job.fin) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_step  <= (r_step == STEP_RAW) ? STEP_PAD : STEP_NFIN;
                                r_state <= S_KINIT;
                            end
                        end
                        STEP_NFIN: begin
                            r_h     <= w_hnew;
                            r_step  <= STEP_SFIN;
                            r_state <= S_KINIT;
                        end
                        STEP_SFIN: begin
                            // hold until the previous digest has gone out
                            if (!r_ebusy) begin
                                r_dig   <= w_hnew;
                                r_ebusy <= 1'b1;
                                r_ecnt  <= '0;
                                r_h     <= '0;
                                r_n     <= '0;
                                r_sig   <= '0;
                                r_state <= S_IDLE;
                            end
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_ebusy;
    assign o_hash_word  = r_dig[511 - 64*r_ecnt -: 64];
    assign o_word_index = r_ecnt;
    assign o_last_word  = (r_ecnt == 3'd7);

endmodule

[src/streebog512_hash_engine_core.sv]
// Streebog-512 hash engine top level: front end, job queue and back end.
// Each block is one compression in the back end: one LPS per cycle, 25 per compression.
// A final block takes 3 compressions (4 when its length is 512 bits or more).
// The digest then leaves as eight transfers, one per cycle unless stalled.
// Input words are taken at one per cycle until the two-entry job queue is full.
// Reset (synchronous, active low) clears chain value, length, checksum and all control.
module streebog512_hash_engine_core
    import sbg_pkg::*;
#(
    parameter int unsigned ROUNDS = ROUNDS_DEF,
    parameter int unsigned QDEPTH = QDEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_data_word,
    input  logic [9:0]  i_block_bits,
    input  logic        i_message_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_hash_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    logic w_push, w_full, w_pop, w_qv;
    t_job w_in_job, w_out_job;

    sbg_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_word   (i_data_word),
        .i_block_bits  (i_block_bits),
        .i_message_end (i_message_end),
        .i_q_full      (w_full),
        .o_q_push      (w_push),
        .o_q_job       (w_in_job)
    );

    sbg_fifo #(.DEPTH(QDEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_in_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qv),
        .o_job   (w_out_job)
    );

    sbg_back #(.ROUNDS(ROUNDS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_qv),
        .i_q_job      (w_out_job),
        .o_q_pop      (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hash_word  (o_hash_word),
        .o_word_index (o_word_index),
        .o_last_word  (o_last_word)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job pushed into a full queue");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_qv)
        else $error("job popped from an empty queue");

    a_word_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_word) |=>
            (o_valid && o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest words out of sequence");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid straight after reset");

endmodule

[sim/tb_streebog512_hash_engine_core.sv]
// Testbench for the Streebog-512 hash engine: directed and random messages checked against a digest predictor.
`timescale 1ns / 1ps

class digest_board;
    logic [63:0] chain [8];
    logic [63:0] length_n [8];
    logic [63:0] checksum [8];
    logic [63:0] blk [8];
    int unsigned slot;
    logic [63:0] want_word [$];
    logic [2:0]  want_idx [$];
    logic        want_last [$];
    int unsigned errors;

    function void clear_msg();
        for (int i = 0; i < 8; i++) begin
            chain[i] = '0;
            length_n[i] = '0;
            checksum[i] = '0;
        end
        slot = 0;
    endfunction

    function logic [511:0] pack8(logic [63:0] a [8]);
        logic [511:0] r;
        for (int i = 0; i < 8; i++) r[511-64*i -: 64] = a[i];
        return r;
    endfunction

    function logic [511:0] sbox_lin(logic [511:0] x);
        logic [511:0] y;
        logic [63:0] v;
        logic [63:0] t;
        for (int w = 0; w < 8; w++) begin
            for (int b = 0; b < 8; b++)
                v[63-8*b -: 8] = sbg_pkg::SBOX[x[511-64*b-8*w -: 8]];
            t = '0;
            for (int j = 0; j < 64; j++)
                if (v[63-j]) t ^= sbg_pkg::LIN[j];
            y[511-64*w -: 64] = t;
        end
        return y;
    endfunction

    function logic [511:0] gn(logic [511:0] h, logic [511:0] n, logic [511:0] m);
        logic [511:0] k;
        logic [511:0] s;
        k = sbox_lin(h ^ n);
        s = k ^ m;
        for (int r = 0; r < 12; r++) begin
            s = sbox_lin(s);
            k = sbox_lin(k ^ sbg_pkg::RC[r]);
            s ^= k;
        end
        return h ^ s ^ m;
    endfunction

    function void absorb_blk(logic [511:0] m, logic [511:0] inc);
        logic [511:0] h;
        logic [511:0] n;
        logic [511:0] c;
        h = gn(pack8(chain), pack8(length_n), m);
        n = pack8(length_n) + inc;
        c = pack8(checksum) + m;
        for (int i = 0; i < 8; i++) begin
            chain[i] = h[511-64*i -: 64];
            length_n[i] = n[511-64*i -: 64];
            checksum[i] = c[511-64*i -: 64];
        end
    endfunction

    function void note_word(logic [63:0] d, logic [9:0] bits, logic fin);
        logic [511:0] m;
        logic [511:0] h;
        int unsigned k;
        blk[slot] = d;
        if (!fin) begin
            if (slot < 7) slot++;
            else begin
                absorb_blk(pack8(blk), 512);
                slot = 0;
            end
            return;
        end
        k = (bits > 512) ? 512 : bits;
        if (k == 512) begin
            absorb_blk(pack8(blk), 512);
            k = 0;
        end
        m = pack8(blk);
        m = (k == 0) ? '0 : (m & ((512'd1 << k) - 1));
        m |= 512'd1 << k;
        absorb_blk(m, k);
        h = gn(pack8(chain), '0, pack8(length_n));
        h = gn(h, '0, pack8(checksum));
        for (int w = 0; w < 8; w++) begin
            want_word = {want_word, h[511-64*w -: 64]};
            want_idx  = {want_idx, w[2:0]};
            want_last = {want_last, (w == 7)};
        end
        clear_msg();
    endfunction

    function void check_word(logic [63:0] hw, logic [2:0] idx, logic lst);
        logic [63:0] ew;
        logic [2:0] ei;
        logic el;
        if (want_word.size() == 0) begin
            $display("%0t: unexpected digest word %h idx %0d", $time, hw, idx);
            errors++;
            return;
        end
        ew = want_word.pop_front();
        ei = want_idx.pop_front();
        el = want_last.pop_front();
        if (hw !== ew || idx !== ei || lst !== el) begin
            $display("%0t: digest mismatch exp %h/%0d/%0b got %h/%0d/%0b",
                     $time, ew, ei, el, hw, idx, lst);
            errors++;
        end
    endfunction

    function new();
        clear_msg();
        errors = 0;
    endfunction
endclass

module tb_streebog512_hash_engine_core;
    import sbg_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [63:0] i_data_word = '0;
    logic [9:0]  i_block_bits = '0;
    logic        i_message_end = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_hash_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    digest_board board = new();
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_off = 1'b0;
    longint unsigned cycles = 0;

    always #1 i_clk = ~i_clk;

    streebog512_hash_engine_core dut (.*);

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("tb_streebog512_hash_engine_core failed");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_word(o_hash_word, o_word_index, o_last_word);
        i_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    // valid stays up after the transfer; the next word or an idle cycle replaces it
    task automatic send_word(logic [63:0] d, logic [9:0] bits, logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_word <= d;
        i_block_bits <= bits;
        i_message_end <= fin;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_word(d, bits, fin);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    // nfull full blocks, then a final block ending on word fin_pos
    task automatic send_msg(int nfull, int fin_pos, logic [9:0] bits, bit extreme);
        logic [63:0] d;
        for (int b = 0; b < nfull; b++)
            for (int w = 0; w < 8; w++) begin
                d = extreme ? {64{b[0]}} : rnd64();
                send_word(d, '0, 1'b0);
            end
        for (int w = 0; w <= fin_pos; w++) begin
            d = extreme ? '1 : rnd64();
            send_word(d, bits, w == fin_pos);
        end
    endtask

    task automatic random_msg();
        int fp;
        logic [9:0] bits;
        fp = ($urandom_range(3) == 0) ? $urandom_range(6) : 7;
        case ($urandom_range(5))
            0: bits = 10'd512;
            1: bits = 10'($urandom_range(1023, 513));
            2: bits = '0;
            default: bits = 10'($urandom_range(511));
        endcase
        send_msg($urandom_range(2), fp, bits, 1'b0);
    endtask

    task automatic drain();
        while (board.want_word.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // full first block so no unwritten buffer word is ever read
        send_msg(0, 7, 10'd0, 1'b1);
        send_msg(0, 7, 10'd512, 1'b1);
        send_msg(1, 7, 10'd1023, 1'b1);
        send_msg(0, 2, 10'd64, 1'b0);
        send_msg(0, 7, 10'd511, 1'b0);
        send_msg(0, 0, 10'd1, 1'b0);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 23 : 68) : 0;
            recv_stall_pct = (ph == 2) ? 68 : ((ph == 3) ? 23 : 0);
            for (int n = 0; n < 4; n++) random_msg();
            if (ph == 0) begin
                hold_off <= 1'b1;
                fork
                    begin
                        repeat (600) @(posedge i_clk);
                        hold_off <= 1'b0;
                    end
                    begin
                        for (int n = 0; n < 4; n++) random_msg();
                        i_valid <= 1'b0;
                        @(posedge i_clk);
                    end
                join
            end
            for (int n = 0; n < 2; n++) random_msg();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_valid <= 1'b0;
        drain();
        repeat (200) @(posedge i_clk);
        if (board.errors == 0 && board.want_word.size() == 0)
            $display("tb_streebog512_hash_engine_core passed");
        else
            $display("tb_streebog512_hash_engine_core failed");
        $finish;
    end
endmodule

[sim.f]
src/sbg_pkg.sv
src/sbg_front.sv
src/sbg_fifo.sv
src/sbg_back.sv
src/streebog512_hash_engine_core.sv
sim/tb_streebog512_hash_engine_core.sv
